### design/fupr_pkg.sv
// Package: types, constants and codes of the firmware update page receiver.
package fupr_pkg;

    localparam int PageBytesDef = 32;

    typedef enum logic [2:0] {
        MODE_ENTER   = 3'd0,
        MODE_PROGRAM = 3'd1,
        MODE_LOAD    = 3'd2,
        MODE_HEADER  = 3'd3,
        MODE_DATA    = 3'd4,
        MODE_LEAVE   = 3'd5
    } t_mode;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_MEM    = 2'd1;
    localparam logic [1:0] KIND_BOOT   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_RESET = 2'd2;

    localparam logic [2:0] REG_MEM_PRESENT = 3'd0;
    localparam logic [2:0] REG_OFF_OFS     = 3'd1;
    localparam logic [2:0] REG_UNOFF_OFS   = 3'd2;
    localparam logic [2:0] REG_OFF_ID      = 3'd3;
    localparam logic [2:0] REG_UNOFF_ID    = 3'd4;
    localparam logic [2:0] REG_REGION_END  = 3'd5;
    localparam logic [2:0] REG_BOOT_CODES  = 3'd6;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] msg_length;
        logic [7:0] value0;
        logic [7:0] value1;
        logic [7:0] value2;
        logic [7:0] value3;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic        needs_reply;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_EMIT,
        S_PAGE,
        S_STATUS
    } t_state;

endpackage

### design/fupr_ram.sv
// Generic single-port-write, registered-read RAM.
module fupr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/firmware_update_page_receiver_unit.sv
// Top level of the firmware update page receiver.
//
// Input channel: i_in_valid / o_in_stall carry one message (t_in_item) per
// transfer. Output channel: o_out_valid / i_out_stall carry result items
// (t_out_item); every message yields zero or more boot and write results
// followed by one status result with last set.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data write one register per
// cycle; write only while idle.
// A message is decided in the cycle after its transfer, then its results are
// loaded into the output register in turn and held while the receiver stalls.
// The status result comes last; a finished page is sent after one prefetch
// read, paced by the single read port of the page buffer.
// One message is handled at a time; o_in_stall is high from transfer until
// the status result is loaded into the output register, so a new message is
// taken only once the last one's status result is loaded.
// Reset (synchronous, active low) clears session state and registers to their
// defaults but r_item, r_base, r_out data and the page buffer (only read full).
// A stalled result is held unchanged in the output register.
module firmware_update_page_receiver_unit
    import fupr_pkg::*;
#(
    parameter int PAGE_BYTES = PageBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    localparam int AW = $clog2(PAGE_BYTES);
    localparam int CW = $clog2(PAGE_BYTES + 1);

    // configuration
    logic        r_mem_present;
    logic [15:0] r_off_ofs, r_unoff_ofs, r_off_id, r_unoff_id, r_region_end;
    logic [23:0] r_boot_codes;

    // session state
    logic [7:0]  r_boot_choice, n_boot_choice;
    logic        r_armed, n_armed;
    logic [15:0] r_image_offset, n_image_offset;
    logic [15:0] r_target, n_target;
    logic [15:0] r_last_page, n_last_page;
    logic        r_page_new, n_page_new;
    logic [5:0]  r_fill, n_fill;
    logic [7:0]  r_exp_seq, n_exp_seq;
    logic        r_miss, n_miss;
    logic [15:0] r_size, n_size;
    logic [15:0] r_written, n_written;
    logic [7:0]  r_pending, n_pending;

    // sequencing
    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [1:0]  r_st, n_st;
    logic        r_resp, n_resp;
    logic [2:0]  r_nwr, n_nwr;     // count of plain writes still to emit
    logic [2:0]  r_widx, n_widx;   // index of plain write
    logic        r_boot_first, n_boot_first;
    logic        r_emit_page, n_emit_page;
    logic [CW-1:0] r_pidx, n_pidx;
    logic [15:0] r_base, n_base;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic [7:0]  ram_rdata;
    logic        ram_we;
    logic [AW-1:0] ram_raddr;

    logic [7:0] fs, of, uf;
    assign fs = r_boot_codes[7:0];
    assign of = r_boot_codes[15:8];
    assign uf = r_boot_codes[23:16];

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_present <= 1'b0;
            r_off_ofs     <= '0;
            r_unoff_ofs   <= '0;
            r_off_id      <= '0;
            r_unoff_id    <= '0;
            r_region_end  <= 16'hFFFF;
            r_boot_codes  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MEM_PRESENT: r_mem_present <= i_cfg_data[0];
                REG_OFF_OFS:     r_off_ofs     <= i_cfg_data[15:0];
                REG_UNOFF_OFS:   r_unoff_ofs   <= i_cfg_data[15:0];
                REG_OFF_ID:      r_off_id      <= i_cfg_data[15:0];
                REG_UNOFF_ID:    r_unoff_id    <= i_cfg_data[15:0];
                REG_REGION_END:  r_region_end  <= i_cfg_data[15:0];
                REG_BOOT_CODES:  r_boot_codes  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // page buffer: written by data messages, read in byte order when a page is emitted
    assign ram_we = (r_state == S_DECIDE) && (r_item.mode == MODE_DATA) && r_armed
                    && (r_pending != 8'd0);

    fupr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(r_item.value0),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // next-state logic
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free && !r_boot_first && r_nwr == 3'd0) begin
                    n_state = r_emit_page ? S_PAGE : S_STATUS;
                end
            end
            S_PAGE: begin
                if (out_free && r_pidx == CW'(PAGE_BYTES)) n_state = S_STATUS;
            end
            S_STATUS: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        logic [15:0] a16;
        logic [8:0]  sum;
        logic        done;
        n_boot_choice = r_boot_choice; n_armed = r_armed;
        n_image_offset = r_image_offset; n_target = r_target;
        n_last_page = r_last_page; n_page_new = r_page_new; n_fill = r_fill;
        n_exp_seq = r_exp_seq; n_miss = r_miss; n_size = r_size;
        n_written = r_written; n_pending = r_pending;
        n_st = r_st; n_resp = r_resp; n_nwr = r_nwr; n_widx = r_widx;
        n_boot_first = r_boot_first; n_emit_page = r_emit_page;
        n_pidx = r_pidx; n_base = r_base;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        ram_raddr = r_pidx[AW-1:0];
        a16  = {r_item.value0, r_item.value1};
        sum  = 9'(r_fill) + 9'(r_item.msg_length) - 9'd1;
        done = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_st = ST_OK; n_resp = 1'b0; n_nwr = '0; n_widx = '0;
                n_boot_first = 1'b0; n_emit_page = 1'b0; n_pidx = '0;
            end
            S_DECIDE: begin
                n_base = (r_boot_choice == of) ? r_off_id : r_unoff_id;
                case (r_item.mode)
                    MODE_ENTER: begin
                        n_resp = 1'b1;
                        if (r_item.msg_length != 8'd1) n_st = ST_FAIL;
                        else begin
                            n_boot_choice = r_item.value0;
                            n_written = '0;
                            n_last_page = 16'hFFFF;
                            if (!r_mem_present || r_item.value0 == fs) begin
                                n_armed = 1'b0; n_boot_first = 1'b1; n_st = ST_RESET;
                            end else if (r_item.value0 == of) begin
                                n_image_offset = r_off_ofs; n_armed = 1'b1;
                            end else if (r_item.value0 == uf) begin
                                n_image_offset = r_unoff_ofs; n_armed = 1'b1;
                            end else begin
                                n_armed = 1'b0; n_st = ST_FAIL;
                            end
                        end
                    end
                    MODE_PROGRAM: begin
                        n_resp = 1'b1;
                        if (r_item.msg_length != 8'd2 || !r_armed) n_st = ST_FAIL;
                        else begin
                            n_size = a16; n_nwr = 3'd6;
                        end
                    end
                    MODE_LOAD: begin
                        if (r_item.msg_length != 8'd2 || !r_armed) n_st = ST_FAIL;
                        else begin
                            n_page_new = (r_last_page != a16);
                            n_target = a16 + r_image_offset;
                            n_fill = '0; n_exp_seq = '0; n_miss = 1'b0; n_pending = '0;
                        end
                    end
                    MODE_HEADER: begin
                        if (!r_armed || r_item.msg_length == 8'd0 || r_pending != 8'd0)
                            n_st = ST_FAIL;
                        else if (r_item.value0 == r_exp_seq
                                 && sum <= 9'(PAGE_BYTES)) begin
                            n_exp_seq = r_exp_seq + 8'd1;
                            n_pending = r_item.msg_length - 8'd1;
                            done = (r_item.msg_length == 8'd1);
                        end else if (r_item.value0 < r_exp_seq) begin
                            n_st = ST_OK;
                        end else begin
                            if (!r_miss) begin
                                n_resp = 1'b1; n_miss = 1'b1;
                            end
                            n_st = ST_FAIL;
                        end
                    end
                    MODE_DATA: begin
                        if (!r_armed || r_pending == 8'd0) n_st = ST_FAIL;
                        else begin
                            n_fill = r_fill + 6'd1;
                            n_pending = r_pending - 8'd1;
                            done = (r_pending == 8'd1);
                        end
                    end
                    MODE_LEAVE: begin
                        n_resp = 1'b1;
                        if (r_item.msg_length != 8'd4 || !r_armed) n_st = ST_FAIL;
                        else if (r_written != r_size && r_written != 16'd0)
                            n_st = ST_FAIL;
                        else begin
                            n_boot_first = 1'b1; n_nwr = 3'd6; n_st = ST_RESET;
                        end
                    end
                    default: n_st = ST_FAIL;
                endcase
                if (done && n_fill == 6'(PAGE_BYTES)) begin
                    n_resp = 1'b1;
                    if (r_page_new) begin
                        n_emit_page = (r_target >= r_off_ofs) && (r_target < r_region_end);
                        n_written = r_written + 16'(PAGE_BYTES);
                        n_last_page = r_target - r_image_offset;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_boot_first) begin
                        n_out_valid = 1'b1;
                        n_out = '{kind: KIND_BOOT, status: ST_OK, needs_reply: 1'b0,
                                  mem_address: 16'd0,
                                  mem_data: (r_item.mode == MODE_ENTER) ? fs
                                                                        : r_boot_choice,
                                  last: 1'b0};
                        n_boot_first = 1'b0;
                    end else if (r_nwr != 3'd0) begin
                        n_out_valid = 1'b1;
                        n_out = '{kind: KIND_MEM, status: ST_OK, needs_reply: 1'b0,
                                  mem_address: r_base + 16'(r_widx), mem_data: 8'd0,
                                  last: 1'b0};
                        if (r_item.mode == MODE_LEAVE) begin
                            case (r_widx)
                                3'd0: n_out.mem_data = r_item.value0;
                                3'd1: n_out.mem_data = r_item.value1;
                                3'd2: n_out.mem_data = r_item.value2;
                                3'd3: n_out.mem_data = r_item.value3;
                                3'd4: n_out.mem_data = r_size[15:8];
                                default: n_out.mem_data = r_size[7:0];
                            endcase
                        end
                        n_nwr = r_nwr - 3'd1; n_widx = r_widx + 3'd1;
                    end else if (r_emit_page) begin
                        // prefetch first byte
                        n_pidx = '0;
                    end
                end
            end
            S_PAGE: begin
                // r_pidx == 0 read is in flight; data for byte pidx-1 is ram_rdata
                if (out_free) begin
                    if (r_pidx != '0) begin
                        n_out_valid = 1'b1;
                        n_out = '{kind: KIND_MEM, status: ST_OK, needs_reply: 1'b0,
                                  mem_address: r_target + 16'(r_pidx - CW'(1)),
                                  mem_data: ram_rdata, last: 1'b0};
                    end
                    if (r_pidx != CW'(PAGE_BYTES)) begin
                        n_pidx = r_pidx + CW'(1);
                        ram_raddr = r_pidx[AW-1:0];
                    end
                end else begin
                    // hold the read so ram_rdata stays on the byte being shown next
                    ram_raddr = AW'(r_pidx - CW'(1));
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{kind: KIND_STATUS, status: r_st, needs_reply: r_resp,
                              mem_address: 16'd0, mem_data: 8'd0, last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_boot_choice <= '0; r_armed <= 1'b0; r_image_offset <= '0;
            r_target <= '0; r_last_page <= 16'hFFFF; r_page_new <= 1'b0;
            r_fill <= '0; r_exp_seq <= '0; r_miss <= 1'b0; r_size <= '0;
            r_written <= '0; r_pending <= '0;
            r_out_valid <= 1'b0;
            r_nwr <= '0; r_widx <= '0; r_boot_first <= 1'b0; r_emit_page <= 1'b0;
            r_pidx <= '0; r_st <= ST_OK; r_resp <= 1'b0;
        end else begin
            r_state <= n_state;
            r_boot_choice <= n_boot_choice; r_armed <= n_armed;
            r_image_offset <= n_image_offset; r_target <= n_target;
            r_last_page <= n_last_page; r_page_new <= n_page_new;
            r_fill <= n_fill; r_exp_seq <= n_exp_seq; r_miss <= n_miss;
            r_size <= n_size; r_written <= n_written; r_pending <= n_pending;
            r_out_valid <= n_out_valid;
            r_nwr <= n_nwr; r_widx <= n_widx; r_boot_first <= n_boot_first;
            r_emit_page <= n_emit_page; r_pidx <= n_pidx;
            r_st <= n_st; r_resp <= n_resp;
        end
        r_base <= n_base;
        r_out  <= n_out;
        if (r_state == S_IDLE && i_in_valid) r_item <= i_in_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> $stable(r_out))
        else $error("output changed under stall");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 6'(PAGE_BYTES))
        else $error("page fill beyond page size");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall)
        else $error("input taken while busy");
`endif
endmodule
